@@ src/plsw_pkg.sv @@
`default_nettype none
package plsw_pkg;

    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [3:0] NIBBLE_MASK  = 4'h0F;
    localparam logic [7:0] BYTE_MASK    = 8'hFF;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_BLIT  = 1'b1;

    localparam logic [1:0] BLEND_OVERWRITE = 2'd0;
    localparam logic [1:0] BLEND_OR        = 2'd1;
    localparam logic [1:0] BLEND_CLEAR     = 2'd2;
    localparam logic [1:0] BLEND_KEEP      = 2'd3;

    localparam logic [1:0] WORD_PAGE     = 2'd0;
    localparam logic [1:0] WORD_COL_HIGH = 2'd1;
    localparam logic [1:0] WORD_COL_LOW  = 2'd2;
    localparam logic [1:0] WORD_DATA     = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] column;
        logic [6:0] row;
        logic [3:0] page;
        logic       set_bit;
        logic [1:0] blend_mode;
        logic       invert;
        logic [7:0] image_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_command;
        logic       last;
        logic [7:0] stored_byte;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic accept;
        logic modify;
        logic send_next;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic addr_ok;
        logic last_word;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ src/page_lcd_shadow_write_engine_core.sv @@
// the input word is taken and the shadow ram read, the modify state writes the new byte,
// then the send state presents the first bus word
// each item passes through read, modify and four bus words; the next read overlaps
// the data word, and the shadow ram's registered read port sets the modify step
// out-of-range items are taken and dropped
// reset: synchronous, active low; a clearing pass over all PAGES*COLUMNS entries (3840 by
// default) zeroes the shadow ram, input not ready until it ends
`default_nettype none
module page_lcd_shadow_write_engine_core
    import plsw_pkg::*;
#(
    parameter int COLUMNS = 240,
    parameter int PAGES   = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    plsw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    plsw_dp #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat)
    );

endmodule
`default_nettype wire

@@ src/plsw_ram.sv @@
`default_nettype none
module plsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3840
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ src/plsw_ctrl.sv @@
`default_nettype none
module plsw_ctrl
    import plsw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SEND
    } t_state;

    t_state r_state;
    logic   in_acc;

    // a new word may enter while the data word of the previous one leaves
    assign o_in_ready  = (r_state == ST_IDLE) ||
                         ((r_state == ST_SEND) && i_stat.last_word && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_SEND);

    always_comb begin
        o_cmd.clear     = (r_state == ST_CLEAR);
        o_cmd.accept    = in_acc;
        o_cmd.modify    = (r_state == ST_MODIFY);
        o_cmd.send_next = (r_state == ST_SEND) && i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (i_stat.clear_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc && i_stat.addr_ok) begin
                        r_state <= ST_MODIFY;
                    end
                end
                ST_MODIFY: begin
                    r_state <= ST_SEND;
                end
                ST_SEND: begin
                    if (i_out_ready && i_stat.last_word) begin
                        // out-of-range words are taken and dropped
                        if (in_acc && i_stat.addr_ok) begin
                            r_state <= ST_MODIFY;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/plsw_dp.sv @@
`default_nettype none
module plsw_dp
    import plsw_pkg::*;
#(
    parameter int COLUMNS = 240,
    parameter int PAGES   = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_word i_in,
    output t_out_word     o_out,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    t_in_word        r_item;
    logic [AW-1:0]   r_addr;
    logic [3:0]      r_page;
    logic [7:0]      r_val;
    logic [1:0]      r_cnt;
    logic [AW-1:0]   r_clr_addr;

    logic [3:0]      page_sel;
    logic [AW-1:0]   addr;
    logic [7:0]      rdata;
    logic [7:0]      src;
    logic [7:0]      mask;
    logic [7:0]      n_val;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [7:0]      wdata;

    assign page_sel = (i_in.cmd == CMD_BLIT) ? i_in.page : i_in.row[6:3];
    assign addr     = AW'(32'(page_sel) * 32'(COLUMNS) + 32'(i_in.column));

    always_comb begin
        o_stat.addr_ok    = (9'(i_in.column) < 9'(COLUMNS)) && (5'(page_sel) < 5'(PAGES));
        o_stat.clear_done = (r_clr_addr == AW'(DEPTH - 1));
        o_stat.last_word  = (r_cnt == WORD_DATA);
    end

    // new byte value from the stored one
    assign src  = r_item.invert ? (r_item.image_byte ^ BYTE_MASK) : r_item.image_byte;
    assign mask = 8'h01 << r_item.row[2:0];

    always_comb begin
        if (r_item.cmd == CMD_BLIT) begin
            case (r_item.blend_mode)
                BLEND_OVERWRITE: n_val = src;
                BLEND_OR:        n_val = rdata | src;
                BLEND_CLEAR:     n_val = rdata & ~src;
                BLEND_KEEP:      n_val = rdata;
                default:         n_val = rdata;
            endcase
        end else begin
            n_val = r_item.set_bit ? (rdata | mask) : (rdata & ~mask);
        end
    end

    assign we    = i_cmd.clear || i_cmd.modify;
    assign waddr = i_cmd.clear ? r_clr_addr : r_addr;
    assign wdata = i_cmd.clear ? 8'h00 : n_val;

    plsw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !o_stat.clear_done) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in;
            r_addr <= addr;
            r_page <= page_sel;
        end
        if (i_cmd.modify) begin
            r_val <= n_val;
            r_cnt <= WORD_PAGE;
        end else if (i_cmd.send_next) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_comb begin
        o_out.stored_byte = r_val;
        o_out.is_command  = 1'b1;
        o_out.last        = 1'b0;
        case (r_cnt)
            WORD_PAGE:     o_out.bus_byte = CMD_PAGE + {4'h0, r_page};
            WORD_COL_HIGH: o_out.bus_byte = CMD_COL_HIGH + {4'h0, r_item.column[7:4]};
            WORD_COL_LOW:  o_out.bus_byte = {4'h0, r_item.column[3:0] & NIBBLE_MASK};
            WORD_DATA: begin
                o_out.bus_byte   = r_val;
                o_out.is_command = 1'b0;
                o_out.last       = 1'b1;
            end
            default:       o_out.bus_byte = r_val;
        endcase
    end

endmodule
`default_nettype wire
